FILE: sv/gcf_pkg.sv
// gcf_pkg: shared constants for the gradient contour filter
// field widths of the item and result ports and configuration register indexes
// no dependencies
package gcf_pkg;

    // fixed port field widths
    localparam int PIX_IN_BITS   = 16;
    localparam int CONTOUR_BITS  = 17;
    localparam int POS_BITS      = 9;
    localparam int CFG_DATA_BITS = 10;
    localparam int CFG_IDX_BITS  = 2;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_FRAME_HEIGHT = 2'd1;

    // reset value of both frame dimension registers
    localparam int DIM_RESET = 512;

endpackage

FILE: sv/gradient_contour_filter.sv
// gradient_contour_filter: L1 forward-difference contour filter on a raster pixel stream
// holds one row in an internal line buffer, one input stage and one result register
// depends on gcf_pkg
// Usage:
//   Pixels enter on the i_in_valid / o_in_ready channel in raster order, one item
//   per accepted handshake. Results leave on o_out_valid / i_out_ready with their
//   row, column, last_of_run and frame_end flags. The result for row r-1 column c
//   comes with pixel (r, c); on the last row the result for column c-1 comes with
//   pixel c, and the final pixel also yields the frame's last result.
//   Frame size is set through the cfg channel (index 0 width, index 1 height);
//   o_cfg_ready is always high and writes belong between frames, with the block idle.
//   Each taken pixel is registered in the input stage, its first result then in the
//   result register; further results of the same pixel follow one per cycle while
//   the receiver takes them. Throughput: one pixel per cycle on all rows but the
//   last while results are taken; on the last row a pixel yields up to two results
//   and the frame's last pixel up to three, one per cycle through the output register.
//   The line buffer is read at two columns per pixel, with registered read data.
//   Reset (synchronous, active low) clears the counters, previous pixel, pending
//   results and output valid, and sets both dimensions to 512; the line buffer is
//   not cleared. When the receiver stalls, the result register holds and the input
//   stage keeps its item; input is taken again once the stage has drained.
module gradient_contour_filter
    import gcf_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int PIXEL_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // pixel input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PIX_IN_BITS-1:0]   i_pixel_value,
    // result output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [CONTOUR_BITS-1:0]  o_contour_value,
    output logic [POS_BITS-1:0]      o_result_row,
    output logic [POS_BITS-1:0]      o_result_column,
    output logic                     o_last_of_run,
    output logic                     o_frame_end,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = CW + 1;
    localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HB = RB + 1;
    localparam int SB = PIXEL_BITS + 1;
    localparam int RST_W = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int RST_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    // absolute difference of two pixels
    function automatic logic [PIXEL_BITS-1:0] abs_diff(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        logic [PIXEL_BITS-1:0] res;
        res = (a >= b) ? (a - b) : (b - a);
        return res;
    endfunction

    // clamp a written width into 1..MAX_WIDTH
    function automatic logic [WB-1:0] clamp_w(input logic [CFG_DATA_BITS-1:0] v);
        logic [WB-1:0] res;
        if (v == '0) begin
            res = WB'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            res = WB'(MAX_WIDTH);
        end else begin
            res = WB'(v);
        end
        return res;
    endfunction

    // clamp a written height into 1..MAX_HEIGHT
    function automatic logic [HB-1:0] clamp_h(input logic [CFG_DATA_BITS-1:0] v);
        logic [HB-1:0] res;
        if (v == '0) begin
            res = HB'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            res = HB'(MAX_HEIGHT);
        end else begin
            res = HB'(v);
        end
        return res;
    endfunction

    // configuration and position state
    logic [WB-1:0]         r_width,  n_width;
    logic [HB-1:0]         r_height, n_height;
    logic [CW-1:0]         r_col,    n_col;
    logic [RB-1:0]         r_row,    n_row;
    logic [PIXEL_BITS-1:0] r_prev;

    // line buffer
    logic [PIXEL_BITS-1:0] r_line [MAX_WIDTH];

    // input stage
    logic [2:0]            r_a_pend, n_a_pend;
    logic [PIXEL_BITS-1:0] r_a_pix;
    logic [PIXEL_BITS-1:0] r_a_prev;
    logic [PIXEL_BITS-1:0] r_a_q0;
    logic [PIXEL_BITS-1:0] r_a_q1;
    logic                  r_a_use_right;
    logic [CW-1:0]         r_a_col;
    logic [RB-1:0]         r_a_row;

    // result register
    logic                    r_o_valid;
    logic [CONTOUR_BITS-1:0] r_o_value;
    logic [POS_BITS-1:0]     r_o_row;
    logic [POS_BITS-1:0]     r_o_col;
    logic                    r_o_last;
    logic                    r_o_fend;

    logic [PIXEL_BITS-1:0] pix_in;
    logic                  in_acc;
    logic                  last_col;
    logic                  last_row;
    logic                  use_right;
    logic [WB-1:0]         col_inc;
    logic [HB-1:0]         row_inc;
    logic [CW-1:0]         rd_addr1;
    logic [2:0]            new_pend;
    logic                  out_free;
    logic                  emit;
    logic [2:0]            sel;
    logic [2:0]            pend_after;
    logic [SB-1:0]         v_below;
    logic [SB-1:0]         v_right;
    logic [SB-1:0]         emit_value;
    logic [POS_BITS-1:0]   emit_row;
    logic [POS_BITS-1:0]   emit_col;

    assign o_cfg_ready = 1'b1;

    // configuration register decode
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  n_width  = clamp_w(i_cfg_data);
                REG_FRAME_HEIGHT: n_height = clamp_h(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WB'(RST_W);
            r_height <= HB'(RST_H);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    // position of the incoming pixel within the frame
    always_comb begin
        pix_in    = i_pixel_value[PIXEL_BITS-1:0];
        col_inc   = {1'b0, r_col} + WB'(1);
        row_inc   = {1'b0, r_row} + HB'(1);
        last_col  = (col_inc >= r_width);
        last_row  = (row_inc >= r_height);
        use_right = !last_col && (col_inc < WB'(MAX_WIDTH));
        rd_addr1  = (col_inc < WB'(MAX_WIDTH)) ? col_inc[CW-1:0] : '0;
        new_pend[0] = (r_row != '0);
        new_pend[1] = last_row && (r_col != '0);
        new_pend[2] = last_row && last_col;
    end

    // counter update on each accepted item
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row_inc[RB-1:0];
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_acc) begin
                r_prev <= pix_in;
            end
        end
    end

    // line buffer: write this column, read this column and the next one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line[r_col] <= pix_in;
            r_a_q0        <= r_line[r_col];
            r_a_q1        <= r_line[rd_addr1];
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_pix       <= pix_in;
            r_a_prev      <= r_prev;
            r_a_use_right <= use_right;
            r_a_col       <= r_col;
            r_a_row       <= r_row;
        end
    end

    // pick the oldest pending result and drain the stage
    always_comb begin
        out_free   = !r_o_valid || i_out_ready;
        sel[0]     = r_a_pend[0];
        sel[1]     = r_a_pend[1] && !r_a_pend[0];
        sel[2]     = r_a_pend[2] && !r_a_pend[1] && !r_a_pend[0];
        emit       = out_free && (r_a_pend != '0);
        pend_after = emit ? (r_a_pend & ~sel) : r_a_pend;
        o_in_ready = (pend_after == '0);
        in_acc     = i_in_valid && o_in_ready;
        n_a_pend   = in_acc ? new_pend : pend_after;
    end

    // result values and positions
    always_comb begin
        v_below = SB'(abs_diff(r_a_pix, r_a_q0));
        if (r_a_use_right) begin
            v_below = v_below + SB'(abs_diff(r_a_q1, r_a_q0));
        end
        v_right = SB'(abs_diff(r_a_pix, r_a_prev));
        if (sel[0]) begin
            emit_value = v_below;
            emit_row   = POS_BITS'(r_a_row - RB'(1));
            emit_col   = POS_BITS'(r_a_col);
        end else if (sel[1]) begin
            emit_value = v_right;
            emit_row   = POS_BITS'(r_a_row);
            emit_col   = POS_BITS'(r_a_col - CW'(1));
        end else begin
            emit_value = '0;
            emit_row   = POS_BITS'(r_a_row);
            emit_col   = POS_BITS'(r_a_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_pend  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_pend <= n_a_pend;
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_value <= CONTOUR_BITS'(emit_value);
            r_o_row   <= emit_row;
            r_o_col   <= emit_col;
            r_o_last  <= ((r_a_pend & ~sel) == '0);
            r_o_fend  <= sel[2];
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_contour_value = r_o_value;
    assign o_result_row    = r_o_row;
    assign o_result_column = r_o_col;
    assign o_last_of_run   = r_o_last;
    assign o_frame_end     = r_o_fend;

    // the stage only takes a new item when at most one result is left in it
    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> ($countones(r_a_pend) <= 1))
        else $error("input ready with more than one pending result");

    // the frame's last result closes its run and carries a zero contour
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_last_of_run && (o_contour_value == '0)))
        else $error("frame end result malformed");

    // a pixel below the first row always schedules the result for the row above
    a_row_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_row != '0)) |=> r_a_pend[0])
        else $error("missing result for previous row");

endmodule

FILE: sim/contour_checker.sv
// contour_checker: result predictor and scoreboard for gradient_contour_filter
// watches the pixel, result and configuration channels; depends on gcf_pkg
`timescale 1ns / 1ps

module contour_checker
    import gcf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // pixel channel
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [PIX_IN_BITS-1:0]   i_pixel_value,
    // result channel
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [CONTOUR_BITS-1:0]  i_contour_value,
    input  logic [POS_BITS-1:0]      i_result_row,
    input  logic [POS_BITS-1:0]      i_result_column,
    input  logic                     i_last_of_run,
    input  logic                     i_frame_end,
    // configuration channel
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // status toward the testbench top
    output int                       o_fail_count,
    output int                       o_pending_results
);

    localparam int unsigned LINE_DEPTH = 512;
    localparam int unsigned ROW_LIMIT  = 512;

    typedef struct packed {
        logic [CONTOUR_BITS-1:0] contour;
        logic [POS_BITS-1:0]     row;
        logic [POS_BITS-1:0]     column;
        logic                    last_of_run;
        logic                    frame_end;
    } t_contour_result;

    // shadow copy of the filter state
    logic [PIX_IN_BITS-1:0]   line_buf [LINE_DEPTH];
    logic [PIX_IN_BITS-1:0]   left_pixel;
    int unsigned              row_pos;
    int unsigned              col_pos;
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;

    t_contour_result expected_contours [$];
    t_contour_result want;
    int              fail_count = 0;

    // zero acts as one, oversize acts as the maximum
    function automatic int unsigned clamp_dim(logic [CFG_DATA_BITS-1:0] v, int unsigned maxv);
        if (v == '0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic logic [CONTOUR_BITS-1:0] abs_gap(logic [PIX_IN_BITS-1:0] a,
                                                        logic [PIX_IN_BITS-1:0] b);
        return (a >= b) ? CONTOUR_BITS'(a - b) : CONTOUR_BITS'(b - a);
    endfunction

    function automatic bit field_matches(string name, logic [31:0] expected_val,
                                         logic [31:0] actual_val);
        if (actual_val === expected_val)
            return 1'b1;
        $error("%s mismatch: expected %0d, actual %0d", name, expected_val, actual_val);
        return 1'b0;
    endfunction

    // work out the contours released by one pixel and advance the raster position
    task automatic predict_contours(input logic [PIX_IN_BITS-1:0] pix);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        int unsigned     ci;
        bit              last_col;
        bit              last_row;
        t_contour_result run [3];
        int              n;
        w        = clamp_dim(width_reg, LINE_DEPTH);
        h        = clamp_dim(height_reg, ROW_LIMIT);
        c        = col_pos;
        r        = row_pos;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        ci       = c % LINE_DEPTH;
        n        = 0;

        // previous row, same column: below minus here plus right minus here
        if (r >= 1) begin
            run[n].contour = abs_gap(pix, line_buf[ci]);
            if (!last_col && c + 1 < LINE_DEPTH)
                run[n].contour += abs_gap(line_buf[c + 1], line_buf[ci]);
            run[n].row         = POS_BITS'(r - 1);
            run[n].column      = POS_BITS'(c);
            run[n].last_of_run = 1'b0;
            run[n].frame_end   = 1'b0;
            n++;
        end
        // last row has no row below, only the horizontal step
        if (last_row) begin
            if (c >= 1) begin
                run[n].contour     = abs_gap(pix, left_pixel);
                run[n].row         = POS_BITS'(r);
                run[n].column      = POS_BITS'(c - 1);
                run[n].last_of_run = 1'b0;
                run[n].frame_end   = 1'b0;
                n++;
            end
            if (last_col) begin
                run[n].contour     = '0;
                run[n].row         = POS_BITS'(r);
                run[n].column      = POS_BITS'(c);
                run[n].last_of_run = 1'b0;
                run[n].frame_end   = 1'b1;
                n++;
            end
        end
        if (n > 0)
            run[n - 1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++)
            expected_contours.push_back(run[k]);

        line_buf[ci] = pix;
        left_pixel   = pix;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // sample all three channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_contours.delete();
            left_pixel = '0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = CFG_DATA_BITS'(DIM_RESET);
            height_reg = CFG_DATA_BITS'(DIM_RESET);
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_FRAME_WIDTH)
                    width_reg = i_cfg_data;
                else if (i_cfg_index == REG_FRAME_HEIGHT)
                    height_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                predict_contours(i_pixel_value);
            if (i_out_valid && i_out_ready) begin
                if (expected_contours.size() == 0) begin
                    $error("result with no item pending: row %0d column %0d contour %0d",
                           i_result_row, i_result_column, i_contour_value);
                    fail_count++;
                end else begin
                    want = expected_contours.pop_front();
                    if (!field_matches("contour_value", 32'(want.contour),
                                       32'(i_contour_value)))
                        fail_count++;
                    if (!field_matches("result_row", 32'(want.row), 32'(i_result_row)))
                        fail_count++;
                    if (!field_matches("result_column", 32'(want.column),
                                       32'(i_result_column)))
                        fail_count++;
                    if (!field_matches("last_of_run", 32'(want.last_of_run),
                                       32'(i_last_of_run)))
                        fail_count++;
                    if (!field_matches("frame_end", 32'(want.frame_end), 32'(i_frame_end)))
                        fail_count++;
                end
            end
        end
        o_fail_count      <= fail_count;
        o_pending_results <= expected_contours.size();
    end

endmodule

FILE: sim/tb.sv
// tb: stimulus and verdict for gradient_contour_filter
// drives pixel frames and frame size writes; checking lives in contour_checker (gcf_pkg)
`timescale 1ns / 1ps

module tb
    import gcf_pkg::*;
;

    localparam t_cfg_idx                 REG_SPARE_A      = 2'd2;
    localparam t_cfg_idx                 REG_SPARE_B      = 2'd3;
    localparam logic [CFG_DATA_BITS-1:0] DIM_OVERSIZE     = '1;
    localparam logic [PIX_IN_BITS-1:0]   PIX_WHITE        = '1;
    localparam logic [PIX_IN_BITS-1:0]   PIX_BLACK        = '0;
    localparam int                       RANDOM_ITEMS     = 190;
    localparam int                       DRAIN_CYCLES     = 4;
    localparam int                       LONG_HOLD_CYCLES = 300;
    localparam int                       CYCLE_LIMIT      = 200000;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic [PIX_IN_BITS-1:0]   i_pixel_value   = '0;
    logic                     i_out_ready     = 1'b0;
    logic                     i_cfg_valid     = 1'b0;
    t_cfg_idx                 i_cfg_index     = REG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0] i_cfg_data      = '0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [CONTOUR_BITS-1:0]  o_contour_value;
    logic [POS_BITS-1:0]      o_result_row;
    logic [POS_BITS-1:0]      o_result_column;
    logic                     o_last_of_run;
    logic                     o_frame_end;
    logic                     o_cfg_ready;

    int fail_count;
    int pending_results;
    int send_idle_pct  = 11;
    int recv_stall_pct = 66;
    bit long_hold_go   = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_left      = 0;
    int cycle_count    = 0;

    gradient_contour_filter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_value   (i_pixel_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_contour_value (o_contour_value),
        .o_result_row    (o_result_row),
        .o_result_column (o_result_column),
        .o_last_of_run   (o_last_of_run),
        .o_frame_end     (o_frame_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    contour_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_pixel_value     (i_pixel_value),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_contour_value   (o_contour_value),
        .i_result_row      (o_result_row),
        .i_result_column   (o_result_column),
        .i_last_of_run     (o_last_of_run),
        .i_frame_end       (o_frame_end),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending_results (pending_results)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (long_hold_go && !long_hold_done) begin
            i_out_ready    <= 1'b0;
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("cycle limit reached with %0d results pending", pending_results);
            $display("gradient_contour_filter regression: fail");
            $finish;
        end
    end

    // offer one pixel item, valid stays high afterwards unless a gap follows
    task automatic send_pixel(input logic [PIX_IN_BITS-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_frame_size(input logic [CFG_DATA_BITS-1:0] width,
                                  input logic [CFG_DATA_BITS-1:0] height);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, drain all results, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] w_data;
        logic [CFG_DATA_BITS-1:0] h_data;
        logic [PIX_IN_BITS-1:0]   pix;
        bit                       extremes_only;
        bit                       hold_armed;
        int                       n_pix;
        int                       random_items;
        hold_armed   = 1'b0;
        random_items = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unknown indexes are ignored; zero width acts as a single column
        write_reg(REG_SPARE_A, DIM_OVERSIZE);
        write_reg(REG_SPARE_B, 10'h155);
        set_frame_size(10'd0, 10'd3);
        send_pixel(PIX_BLACK);
        send_pixel(PIX_WHITE);
        send_pixel(16'h5555);

        // 2x2 frame reaching the largest contour
        wait_idle();
        set_frame_size(10'd2, 10'd2);
        send_pixel(PIX_BLACK);
        send_pixel(PIX_WHITE);
        send_pixel(PIX_WHITE);
        send_pixel(16'hAAAA);

        // single row, zero height acts as one
        wait_idle();
        set_frame_size(10'd4, 10'd0);
        send_pixel(PIX_WHITE);
        send_pixel(PIX_BLACK);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);

        // single pixel frame
        wait_idle();
        set_frame_size(10'd1, 10'd1);
        send_pixel(16'h1234);

        // oversize width, then narrowed in the middle of the first row
        wait_idle();
        set_frame_size(DIM_OVERSIZE, 10'd2);
        send_pixel(16'h0F0F);
        send_pixel(16'hF0F0);
        send_pixel(16'h8001);
        send_pixel(16'h7FFE);
        send_pixel(16'h00FF);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 10'd3);
        i_cfg_valid <= 1'b0;
        send_pixel(16'h1234);
        send_pixel(PIX_WHITE);
        send_pixel(PIX_BLACK);
        send_pixel(16'h8000);

        // oversize height, then cut below the current row
        wait_idle();
        set_frame_size(10'd2, DIM_OVERSIZE);
        send_pixel(16'h4321);
        send_pixel(PIX_WHITE);
        send_pixel(PIX_BLACK);
        send_pixel(16'hC3C3);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 10'd1);
        i_cfg_valid <= 1'b0;
        send_pixel(16'h3C3C);
        send_pixel(PIX_WHITE);

        // random frames in three idling phases
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end else if (random_items >= RANDOM_ITEMS / 3) begin
                send_idle_pct  <= 66;
                recv_stall_pct <= 11;
            end
            w_data = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 12));
            h_data = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(1, 5));
            if (!hold_armed && random_items >= 2 * RANDOM_ITEMS / 3) begin
                w_data = 10'd12;
                h_data = 10'd5;
            end
            extremes_only = ($urandom_range(3) == 0);
            n_pix = ((w_data == 0) ? 1 : int'(w_data)) * ((h_data == 0) ? 1 : int'(h_data));
            wait_idle();
            set_frame_size(w_data, h_data);
            // long receiver hold-off while the sender keeps offering
            if (!hold_armed && random_items >= 2 * RANDOM_ITEMS / 3) begin
                long_hold_go <= 1'b1;
                hold_armed = 1'b1;
            end
            repeat (n_pix) begin
                if (extremes_only)
                    pix = $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
                else
                    pix = PIX_IN_BITS'($urandom);
                send_pixel(pix);
                random_items++;
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("gradient_contour_filter regression: pass");
        else
            $display("gradient_contour_filter regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/gcf_pkg.sv
sv/gradient_contour_filter.sv
sim/contour_checker.sv
sim/tb.sv
